// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL modules.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CHK_IMPLY(lbl, cond, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("implication check failed");

// Next-cycle implication, disabled while reset is high.
`define CHK_NEXT(lbl, cond, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("next-cycle check failed");

`endif

// ===== hdl/sldfr_pkg.sv =====
`default_nettype none

package sldfr_pkg;

   localparam logic [7:0] SYNC_FIRST  = 8'hCC;
   localparam logic [7:0] SYNC_SECOND = 8'h44;

   // Configuration register indexes.
   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IDX_COUNT  = 3'd0;
   localparam int                         CSR_IDX_ENTRY0 = 1;
   localparam int                         TABLE_REGS     = 4;

   localparam int COUNT_WIDTH = 3;
   localparam int ENTRY_WIDTH = 16;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [1:0] VERDICT_MATCHED         = 2'd0;
   localparam logic [1:0] VERDICT_UNKNOWN_MODULE  = 2'd1;
   localparam logic [1:0] VERDICT_UNKNOWN_COMMAND = 2'd2;

   // Result queue geometry.
   localparam int FIFO_DEPTH     = 4;
   localparam int FIFO_PTR_WIDTH = 2;
   localparam int FIFO_CNT_WIDTH = 3;

   typedef enum logic [3:0] {
      PH_HUNT,
      PH_SYNC2,
      PH_MODULE,
      PH_COMMAND,
      PH_STATUS,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_CHK_HI,
      PH_CHK_LO,
      PH_DATA
   } phase_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      logic [7:0]  module_id;
      logic [7:0]  command_id;
      logic [7:0]  status_byte;
      logic [15:0] payload_length;
      logic [15:0] check_word;
      logic [1:0]  verdict;
      logic [1:0]  entry_index;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] verdict;
      logic [1:0] entry_index;
   } match_type;

   typedef struct packed {
      logic one;
      logic two;
   } push_type;

endpackage

`default_nettype wire

// ===== hdl/sldfr_match.sv =====
`default_nettype none

// Compares held module and command bytes with each entry below the count in
// parallel; the lowest entry matching both wins, else unknown command/module.
module sldfr_match #(
   parameter int TABLE_ENTRIES = 4
) (
   input  wire logic [7:0]                        module_id,
   input  wire logic [7:0]                        command_id,
   input  wire logic [sldfr_pkg::COUNT_WIDTH-1:0] entry_count,
   input  wire logic [sldfr_pkg::ENTRY_WIDTH-1:0] table_entries [TABLE_ENTRIES],
   output sldfr_pkg::match_type                   result
);
   import sldfr_pkg::*;

   logic       module_seen;
   logic       matched;
   logic [1:0] hit_index;

   always_comb begin
      module_seen = 1'b0;
      matched     = 1'b0;
      hit_index   = 2'd0;
      // Descending scan so the lowest matching entry is the one kept.
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if ((i < int'(entry_count)) && (table_entries[i][15:8] == module_id)) begin
            module_seen = 1'b1;
            if (table_entries[i][7:0] == command_id) begin
               matched   = 1'b1;
               hit_index = 2'(i);
            end
         end
      end
   end

   always_comb begin
      if (matched) begin
         result.verdict     = VERDICT_MATCHED;
         result.entry_index = hit_index;
      end else if (module_seen) begin
         result.verdict     = VERDICT_UNKNOWN_COMMAND;
         result.entry_index = 2'd0;
      end else begin
         result.verdict     = VERDICT_UNKNOWN_MODULE;
         result.entry_index = 2'd0;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/sldfr_parse.sv =====
`default_nettype none
`include "assert_macros.svh"

// Byte-serial header parser. Holds the header fields and the payload
// countdown, and builds up to two results for each accepted byte.
module sldfr_parse (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic [7:0]           rx_byte,
   input  sldfr_pkg::match_type      match,
   output logic [7:0]                held_module,
   output logic [7:0]                held_command,
   output sldfr_pkg::push_type       push,
   output sldfr_pkg::rsp_type        rsp0,
   output sldfr_pkg::rsp_type        rsp1
);
   import sldfr_pkg::*;

   phase_type   phase_ff,     phase_in;
   logic [7:0]  module_ff,    module_in;
   logic [7:0]  command_ff,   command_in;
   logic [7:0]  status_ff,    status_in;
   logic [15:0] length_ff,    length_in;
   logic [15:0] check_ff,     check_in;
   logic [15:0] remaining_ff, remaining_in;

   rsp_type     summary;
   logic        last_data;

   assign last_data = (remaining_ff == 16'd1);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == SYNC_FIRST) phase_in = PH_SYNC2;
         end
         PH_SYNC2: begin
            if (rx_byte == SYNC_SECOND)     phase_in = PH_MODULE;
            else if (rx_byte == SYNC_FIRST) phase_in = PH_SYNC2;
            else                            phase_in = PH_HUNT;
         end
         PH_MODULE:  phase_in = PH_COMMAND;
         PH_COMMAND: phase_in = PH_STATUS;
         PH_STATUS:  phase_in = PH_LEN_HI;
         PH_LEN_HI:  phase_in = PH_LEN_LO;
         PH_LEN_LO:  phase_in = PH_CHK_HI;
         PH_CHK_HI:  phase_in = PH_CHK_LO;
         PH_CHK_LO:  phase_in = (remaining_ff != 16'd0) ? PH_DATA : PH_HUNT;
         PH_DATA:    phase_in = last_data ? PH_HUNT : PH_DATA;
         default:    phase_in = PH_HUNT;
      endcase
   end

   // Next values of the held header fields.
   always_comb begin
      module_in    = module_ff;
      command_in   = command_ff;
      status_in    = status_ff;
      length_in    = length_ff;
      check_in     = check_ff;
      remaining_in = remaining_ff;
      case (phase_ff)
         PH_MODULE:  module_in  = rx_byte;
         PH_COMMAND: command_in = rx_byte;
         PH_STATUS:  status_in  = rx_byte;
         PH_LEN_HI:  length_in  = {rx_byte, 8'h00};
         PH_LEN_LO: begin
            length_in    = {length_ff[15:8], rx_byte};
            remaining_in = {length_ff[15:8], rx_byte};
         end
         PH_CHK_HI:  check_in     = {rx_byte, 8'h00};
         PH_CHK_LO:  check_in     = {check_ff[15:8], rx_byte};
         PH_DATA:    remaining_in = remaining_ff - 16'd1;
         default: begin
         end
      endcase
   end

   // Results. The summary on the second check byte already carries that byte.
   always_comb begin
      summary                = '0;
      summary.kind           = KIND_SUMMARY;
      summary.module_id      = module_ff;
      summary.command_id     = command_ff;
      summary.status_byte    = status_ff;
      summary.payload_length = length_ff;
      summary.check_word     = (phase_ff == PH_CHK_LO) ? {check_ff[15:8], rx_byte}
                                                       : check_ff;
      summary.verdict        = match.verdict;
      summary.entry_index    = match.entry_index;
      summary.last           = 1'b1;

      push = '0;
      rsp0 = '0;
      rsp1 = summary;
      case (phase_ff)
         PH_CHK_LO: begin
            if (remaining_ff == 16'd0) begin
               push.one = accept;
               rsp0     = summary;
            end
         end
         PH_DATA: begin
            rsp0.kind         = KIND_PAYLOAD;
            rsp0.payload_byte = rx_byte;
            rsp0.last         = !last_data;
            push.one          = accept && !last_data;
            push.two          = accept && last_data;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         module_ff    <= '0;
         command_ff   <= '0;
         status_ff    <= '0;
         length_ff    <= '0;
         check_ff     <= '0;
         remaining_ff <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         module_ff    <= module_in;
         command_ff   <= command_in;
         status_ff    <= status_in;
         length_ff    <= length_in;
         check_ff     <= check_in;
         remaining_ff <= remaining_in;
      end
   end

   assign held_module  = module_ff;
   assign held_command = command_ff;

   `CHK_IMPLY(a_data_has_bytes, phase_ff == PH_DATA, remaining_ff != 16'd0)
   `CHK_IMPLY(a_two_only_in_data, push.two, phase_ff == PH_DATA && last_data)
   `CHK_IMPLY(a_one_push_kind, push.one && push.two, 1'b0)

endmodule

`default_nettype wire

// ===== hdl/sldfr_rsp_fifo.sv =====
`default_nettype none
`include "assert_macros.svh"

// Small result queue: takes one or two results per cycle, gives one per cycle while rd_ready is high.
module sldfr_rsp_fifo (
   input  wire logic           clock,
   input  wire logic           reset,
   input  sldfr_pkg::push_type push,
   input  sldfr_pkg::rsp_type  wr0,
   input  sldfr_pkg::rsp_type  wr1,
   output logic                room_for_two,
   output logic                rd_valid,
   input  wire logic           rd_ready,
   output sldfr_pkg::rsp_type  rd_data
);
   import sldfr_pkg::*;

   rsp_type                   slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_WIDTH-1:0] count_ff,  count_in;
   logic [FIFO_PTR_WIDTH-1:0] wr_ptr_next;
   logic                      pop;
   logic [FIFO_CNT_WIDTH-1:0] push_count;

   assign pop          = rd_valid && rd_ready;
   assign rd_valid     = (count_ff != '0);
   assign rd_data      = slot_ff[rd_ptr_ff];
   assign room_for_two = (count_ff <= FIFO_CNT_WIDTH'(FIFO_DEPTH - 2));
   assign wr_ptr_next  = wr_ptr_ff + FIFO_PTR_WIDTH'(1);

   always_comb begin
      push_count = push.two ? FIFO_CNT_WIDTH'(2)
                 : (push.one ? FIFO_CNT_WIDTH'(1) : '0);
      wr_ptr_in  = wr_ptr_ff + push_count[FIFO_PTR_WIDTH-1:0];
      rd_ptr_in  = pop ? rd_ptr_ff + FIFO_PTR_WIDTH'(1) : rd_ptr_ff;
      count_in   = count_ff + push_count - (pop ? FIFO_CNT_WIDTH'(1) : '0);
   end

   always_ff @(posedge clock) begin
      if (push.one || push.two) slot_ff[wr_ptr_ff] <= wr0;
      if (push.two)             slot_ff[wr_ptr_next] <= wr1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `CHK_IMPLY(a_two_fits, push.two, count_ff <= FIFO_CNT_WIDTH'(FIFO_DEPTH - 2))
   `CHK_IMPLY(a_count_bound, 1'b1, count_ff <= FIFO_CNT_WIDTH'(FIFO_DEPTH))
   `CHK_NEXT(a_pop_drains, pop && !push.one && !push.two,
             count_ff == $past(count_ff) - FIFO_CNT_WIDTH'(1))

endmodule

`default_nettype wire

// ===== hdl/sync_length_packet_deframer.sv =====
// Channel   Ports                              Direction  Transaction
// req       req_valid/req_ready, req_rx_byte   in         one received byte
// rsp       rsp_valid/rsp_ready, rsp_*         out        payload byte or summary
// csr       csr_valid/csr_ready, csr_index/data in        table register write
//
// One byte is taken per cycle while req_ready is high; the parser decodes it
// in the cycle it is taken. Results land in a four-entry queue and are shown
// from the cycle after. req_ready is high while the queue has room for two
// results, since the last payload byte of a packet produces both the byte and
// the packet summary. Synchronous active-high reset returns the parser to sync
// hunting, empties the queue and clears the table. csr_ready is always high.
`default_nettype none

module sync_length_packet_deframer #(
   parameter int TABLE_ENTRIES = 4
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,

   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [7:0]                           req_rx_byte,

   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_kind,
   output logic [7:0]                                rsp_payload_byte,
   output logic [7:0]                                rsp_module_id,
   output logic [7:0]                                rsp_command_id,
   output logic [7:0]                                rsp_status_byte,
   output logic [15:0]                               rsp_payload_length,
   output logic [15:0]                               rsp_check_word,
   output logic [1:0]                                rsp_verdict,
   output logic [1:0]                                rsp_entry_index,
   output logic                                      rsp_last,

   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [sldfr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [15:0]                          csr_data
);
   import sldfr_pkg::*;

   // Configuration: entry count plus the command table. Only the first
   // TABLE_REGS entries can be written; any further entries read as zero
   // but still take part in matching when the entry count reaches them.
   logic [COUNT_WIDTH-1:0] entry_count_ff;
   logic [ENTRY_WIDTH-1:0] table_entries [TABLE_ENTRIES];
   logic                   csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_write && (csr_index == CSR_IDX_COUNT)) begin
         entry_count_ff <= csr_data[COUNT_WIDTH-1:0];
      end
   end

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_table
      if (i < TABLE_REGS) begin : g_reg
         logic [ENTRY_WIDTH-1:0] entry_ff;
         always_ff @(posedge clock) begin
            if (reset) begin
               entry_ff <= '0;
            end else if (csr_write &&
                         (csr_index == CSR_INDEX_WIDTH'(CSR_IDX_ENTRY0 + i))) begin
               entry_ff <= csr_data;
            end
         end
         assign table_entries[i] = entry_ff;
      end else begin : g_zero
         assign table_entries[i] = '0;
      end
   end

   // Parser, table matcher and result queue.
   logic       req_accept;
   logic       room_for_two;
   logic [7:0] held_module;
   logic [7:0] held_command;
   match_type  match;
   push_type   push;
   rsp_type    rsp0;
   rsp_type    rsp1;
   rsp_type    head;

   assign req_ready  = room_for_two;
   assign req_accept = req_valid && req_ready;

   sldfr_match #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_match (
      .module_id     (held_module),
      .command_id    (held_command),
      .entry_count   (entry_count_ff),
      .table_entries (table_entries),
      .result        (match)
   );

   sldfr_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .rx_byte      (req_rx_byte),
      .match        (match),
      .held_module  (held_module),
      .held_command (held_command),
      .push         (push),
      .rsp0         (rsp0),
      .rsp1         (rsp1)
   );

   sldfr_rsp_fifo u_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .wr0          (rsp0),
      .wr1          (rsp1),
      .room_for_two (room_for_two),
      .rd_valid     (rsp_valid),
      .rd_ready     (rsp_ready),
      .rd_data      (head)
   );

   // The queue head drives the result ports directly.
   assign rsp_kind           = head.kind;
   assign rsp_payload_byte   = head.payload_byte;
   assign rsp_module_id      = head.module_id;
   assign rsp_command_id     = head.command_id;
   assign rsp_status_byte    = head.status_byte;
   assign rsp_payload_length = head.payload_length;
   assign rsp_check_word     = head.check_word;
   assign rsp_verdict        = head.verdict;
   assign rsp_entry_index    = head.entry_index;
   assign rsp_last           = head.last;

endmodule

`default_nettype wire

// ===== verif/tb_sync_length_packet_deframer.sv =====
`default_nettype none

module tb_sync_length_packet_deframer;
   timeunit 1ns;
   timeprecision 1ps;

   import sldfr_pkg::*;

   // One byte waiting to be offered on the request channel. A drain byte is
   // held back until every predicted result has been taken. A hold byte asks
   // the receiver for a long stall when it goes out.
   typedef struct {
      logic [7:0] rx;
      bit         drain;
      bit         hold;
   } tx_byte_type;

   // Length of the long receiver stall, in clock cycles.
   localparam int LONG_STALL_CYCLES = 60;
   // Cycles allowed for results still in flight after the last one we expect.
   localparam int SETTLE_CYCLES = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid   = 1'b0;
   logic                       req_ready;
   logic [7:0]                 req_rx_byte = 8'h00;

   logic                       rsp_valid;
   logic                       rsp_ready   = 1'b0;
   logic                       rsp_kind;
   logic [7:0]                 rsp_payload_byte;
   logic [7:0]                 rsp_module_id;
   logic [7:0]                 rsp_command_id;
   logic [7:0]                 rsp_status_byte;
   logic [15:0]                rsp_payload_length;
   logic [15:0]                rsp_check_word;
   logic [1:0]                 rsp_verdict;
   logic [1:0]                 rsp_entry_index;
   logic                       rsp_last;

   logic                       csr_valid   = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index   = '0;
   logic [15:0]                csr_data    = 16'h0000;

   sync_length_packet_deframer u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_module_id      (rsp_module_id),
      .rsp_command_id     (rsp_command_id),
      .rsp_status_byte    (rsp_status_byte),
      .rsp_payload_length (rsp_payload_length),
      .rsp_check_word     (rsp_check_word),
      .rsp_verdict        (rsp_verdict),
      .rsp_entry_index    (rsp_entry_index),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #5 clock = ~clock;

   // Handshake flags, sampled at each rising edge by the monitor and read by
   // the driver, the receiver and the register writer at the falling edge.
   bit req_fire = 1'b0;
   bit rsp_fire = 1'b0;
   bit csr_fire = 1'b0;

   // Bytes still to be offered, and the results the parser owes us, oldest
   // first.
   tx_byte_type bytes_to_send[$];
   rsp_type     results_due[$];
   int          errors = 0;

   // Idle settings of the current phase. Each side draws a wait from zero up
   // to its maximum for every transaction.
   int send_gap_max = 0;
   int take_gap_max = 0;
   int send_wait    = 0;
   int take_wait    = 0;
   int hold_asked   = 0;
   int hold_served  = 0;
   int hold_left    = 0;

   // Shadow of the command table as it was written through the register port.
   logic [COUNT_WIDTH-1:0] tbl_count = '0;
   logic [ENTRY_WIDTH-1:0] tbl_entry[TABLE_REGS] = '{default: '0};

   // Shadow of the parser state.
   phase_type   parse_state = PH_HUNT;
   logic [7:0]  pkt_module  = 8'h00;
   logic [7:0]  pkt_command = 8'h00;
   logic [7:0]  pkt_status  = 8'h00;
   logic [15:0] pkt_length  = 16'h0000;
   logic [15:0] pkt_check   = 16'h0000;
   logic [15:0] bytes_left  = 16'h0000;

   // Stimulus bookkeeping: bytes queued in the current phase, and one-shot
   // marks for the next byte queued.
   int queued     = 0;
   bit mark_hold  = 1'b0;
   bit mark_drain = 1'b0;

   // A register write only lands on a defined index. Count keeps its low
   // three bits; indexes past the last table entry are dropped.
   function automatic void apply_reg_write(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                           input logic [15:0] val);
      if (idx == CSR_IDX_COUNT) begin
         tbl_count = val[COUNT_WIDTH-1:0];
      end else if (idx >= CSR_IDX_ENTRY0 && idx < CSR_IDX_ENTRY0 + TABLE_REGS) begin
         tbl_entry[idx - CSR_IDX_ENTRY0] = val;
      end
   endfunction

   // The summary looks for the first valid entry that matches both module and
   // command. A module seen without its command gives unknown command; a
   // module seen nowhere gives unknown module. A count above the table size
   // is clipped to the table size.
   function automatic rsp_type packet_summary();
      rsp_type s;
      int      lim;
      int      i;
      bit      mod_hit;
      bit      cmd_hit;
      s       = '0;
      mod_hit = 1'b0;
      cmd_hit = 1'b0;
      lim     = (tbl_count > TABLE_REGS) ? TABLE_REGS : int'(tbl_count);
      for (i = 0; i < lim && !cmd_hit; i++) begin
         if (tbl_entry[i][15:8] == pkt_module) begin
            mod_hit = 1'b1;
            if (tbl_entry[i][7:0] == pkt_command) begin
               cmd_hit       = 1'b1;
               s.entry_index = i[1:0];
            end
         end
      end
      s.kind           = KIND_SUMMARY;
      s.module_id      = pkt_module;
      s.command_id     = pkt_command;
      s.status_byte    = pkt_status;
      s.payload_length = pkt_length;
      s.check_word     = pkt_check;
      s.verdict        = cmd_hit ? VERDICT_MATCHED :
                         (mod_hit ? VERDICT_UNKNOWN_COMMAND : VERDICT_UNKNOWN_MODULE);
      s.last           = 1'b1;
      return s;
   endfunction

   // Moves the shadow parser by one received byte and queues whatever it
   // produces. A byte after the first sync byte that is not the second one
   // is looked at again as a first sync byte. An empty packet closes on the
   // low check byte; the last payload byte yields the byte and the summary,
   // and only the summary carries the last flag then.
   function automatic void advance_parser(input logic [7:0] b);
      rsp_type r;
      case (parse_state)
         PH_HUNT: begin
            if (b == SYNC_FIRST) parse_state = PH_SYNC2;
         end
         PH_SYNC2: begin
            if (b == SYNC_SECOND)     parse_state = PH_MODULE;
            else if (b == SYNC_FIRST) parse_state = PH_SYNC2;
            else                      parse_state = PH_HUNT;
         end
         PH_MODULE: begin
            pkt_module  = b;
            parse_state = PH_COMMAND;
         end
         PH_COMMAND: begin
            pkt_command = b;
            parse_state = PH_STATUS;
         end
         PH_STATUS: begin
            pkt_status  = b;
            parse_state = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            pkt_length  = {b, 8'h00};
            parse_state = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            pkt_length[7:0] = b;
            bytes_left      = pkt_length;
            parse_state     = PH_CHK_HI;
         end
         PH_CHK_HI: begin
            pkt_check   = {b, 8'h00};
            parse_state = PH_CHK_LO;
         end
         PH_CHK_LO: begin
            pkt_check[7:0] = b;
            if (bytes_left != 0) begin
               parse_state = PH_DATA;
            end else begin
               results_due.push_back(packet_summary());
               parse_state = PH_HUNT;
            end
         end
         PH_DATA: begin
            r              = '0;
            r.kind         = KIND_PAYLOAD;
            r.payload_byte = b;
            bytes_left     = bytes_left - 16'd1;
            r.last         = (bytes_left != 0);
            results_due.push_back(r);
            if (bytes_left == 0) begin
               results_due.push_back(packet_summary());
               parse_state = PH_HUNT;
            end
         end
         default: begin
            parse_state = PH_HUNT;
         end
      endcase
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // Monitor. At every rising edge it records which channels completed a
   // transaction, updates the shadow table and parser, and checks each
   // result against the oldest prediction. Predictions go in before the
   // check so that a result is never compared ahead of the byte it comes
   // from.
   always @(posedge clock) begin
      rsp_type seen;
      rsp_type want;
      req_fire = !reset && req_valid && req_ready;
      rsp_fire = !reset && rsp_valid && rsp_ready;
      csr_fire = !reset && csr_valid && csr_ready;
      if (csr_fire) apply_reg_write(csr_index, csr_data);
      if (req_fire) advance_parser(req_rx_byte);
      if (rsp_fire) begin
         seen = '{rsp_kind, rsp_payload_byte, rsp_module_id, rsp_command_id,
                  rsp_status_byte, rsp_payload_length, rsp_check_word,
                  rsp_verdict, rsp_entry_index, rsp_last};
         if (results_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual kind %0b byte %0h",
                     $time, seen.kind, seen.payload_byte);
         end else begin
            want = results_due.pop_front();
            check_field("kind",           want.kind,           seen.kind);
            check_field("payload_byte",   want.payload_byte,   seen.payload_byte);
            check_field("module_id",      want.module_id,      seen.module_id);
            check_field("command_id",     want.command_id,     seen.command_id);
            check_field("status_byte",    want.status_byte,    seen.status_byte);
            check_field("payload_length", want.payload_length, seen.payload_length);
            check_field("check_word",     want.check_word,     seen.check_word);
            check_field("verdict",        want.verdict,        seen.verdict);
            check_field("entry_index",    want.entry_index,    seen.entry_index);
            check_field("last",           want.last,           seen.last);
         end
      end
   end

   // Driver. Once a byte is accepted it draws the gap before the next one.
   // A byte marked to drain waits until the parser owes nothing. Valid only
   // falls when the current byte has gone and nothing new is ready.
   always @(negedge clock) begin
      tx_byte_type slot;
      if (!reset) begin
         if (req_fire) send_wait = $urandom_range(0, send_gap_max);
         if (!req_valid || req_fire) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (bytes_to_send.size() != 0 &&
                         !(bytes_to_send[0].drain && results_due.size() != 0)) begin
               slot = bytes_to_send.pop_front();
               if (slot.hold) hold_asked++;
               req_valid   <= 1'b1;
               req_rx_byte <= slot.rx;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver. It stalls for a drawn number of cycles after each result, and
   // once per hold byte it stalls for a long stretch so that the result queue
   // fills and the request channel backs up.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_fire) take_wait = $urandom_range(0, take_gap_max);
         if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = LONG_STALL_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (take_wait > 0) begin
            take_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic void push_byte(input logic [7:0] b);
      tx_byte_type slot;
      slot.rx    = b;
      slot.drain = mark_drain;
      slot.hold  = mark_hold;
      mark_drain = 1'b0;
      mark_hold  = 1'b0;
      bytes_to_send.push_back(slot);
      queued++;
   endfunction

   // Payload bytes lean toward the sync values so that stray sync patterns
   // inside a packet are exercised.
   function automatic logic [7:0] random_content();
      case ($urandom_range(0, 7))
         0:       return SYNC_FIRST;
         1:       return SYNC_SECOND;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void add_packet(input logic [7:0] mod, input logic [7:0] cmd,
                                      input logic [15:0] len);
      logic [15:0] chk;
      int          k;
      chk = 16'($urandom_range(0, 65535));
      push_byte(SYNC_FIRST);
      push_byte(SYNC_SECOND);
      push_byte(mod);
      push_byte(cmd);
      push_byte(8'($urandom_range(0, 255)));
      push_byte(len[15:8]);
      push_byte(len[7:0]);
      push_byte(chk[15:8]);
      push_byte(chk[7:0]);
      for (k = 0; k < len; k++) push_byte(random_content());
   endfunction

   // One random unit: mostly a well-formed packet whose module and command
   // often come from the current table, otherwise line noise or a first sync byte
   // that breaks off.
   function automatic void add_random_unit();
      logic [15:0] pick;
      logic [15:0] len;
      int          sel;
      int          k;
      sel  = $urandom_range(0, 99);
      pick = tbl_entry[$urandom_range(0, TABLE_REGS - 1)];
      if (sel < 70) begin
         case ($urandom_range(0, 9))
            0:       len = 16'd0;
            1:       len = 16'($urandom_range(9, 40));
            default: len = 16'($urandom_range(1, 8));
         endcase
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: add_packet(pick[15:8], pick[7:0], len);
            8, 9, 10, 11, 12:       add_packet(pick[15:8], 8'($urandom_range(0, 255)), len);
            default: add_packet(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len);
         endcase
      end else if (sel < 85) begin
         for (k = $urandom_range(1, 6); k > 0; k--) begin
            push_byte(($urandom_range(0, 3) == 0) ? SYNC_FIRST : 8'($urandom_range(0, 255)));
         end
      end else begin
         push_byte(SYNC_FIRST);
         if ($urandom_range(0, 1)) push_byte(SYNC_FIRST);
         push_byte(8'($urandom_range(0, 255)));
      end
   endfunction

   // Waits until every byte is sent and every predicted result has come,
   // then lets the block settle, since a byte that yields no result may
   // still be in the pipeline.
   task automatic wait_idle();
      while (bytes_to_send.size() != 0 || req_valid || results_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write, issued at a falling edge. Valid stays up across back to
   // back writes; the caller lowers it after the last one.
   task automatic write_reg(input int idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= CSR_INDEX_WIDTH'(idx);
      csr_data  <= val;
      do @(negedge clock); while (!csr_fire);
   endtask

   // Main sequence. Each phase after the first programs the table while the block is idle,
   // picks the idle behavior of both sides and queues its bytes. The first
   // phase runs on the reset table, where every module is unknown.
   initial begin
      int ph;
      int target;
      int k;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (ph = 0; ph < 6; ph++) begin
         wait_idle();
         @(negedge clock);
         target = (ph == 0) ? 100 : 250;
         queued = 0;
         case (ph)
            1: begin
               write_reg(CSR_IDX_ENTRY0 + 0, 16'h1020);
               write_reg(CSR_IDX_ENTRY0 + 1, 16'h1030);
               write_reg(CSR_IDX_ENTRY0 + 2, 16'h5500);
               write_reg(CSR_IDX_ENTRY0 + 3, 16'hFFFF);
               write_reg(int'(CSR_IDX_COUNT), 16'd4);
               csr_valid    <= 1'b0;
               send_gap_max  = 0;
               take_gap_max  = 0;
            end
            2: begin
               // An oversized count covers the whole table, and writes to
               // indexes past the table must change nothing.
               write_reg(CSR_IDX_ENTRY0 + 0, 16'h0000);
               write_reg(CSR_IDX_ENTRY0 + 1, 16'hFFFF);
               write_reg(CSR_IDX_ENTRY0 + 2, 16'h00FF);
               write_reg(CSR_IDX_ENTRY0 + 3, 16'hFF00);
               for (k = CSR_IDX_ENTRY0 + TABLE_REGS; k < 2 ** CSR_INDEX_WIDTH; k++) begin
                  write_reg(k, 16'hFFFF);
               end
               write_reg(int'(CSR_IDX_COUNT), 16'hFFFF);
               csr_valid    <= 1'b0;
               send_gap_max  = 0;
               take_gap_max  = 14;
               mark_hold     = 1'b1;
            end
            3: begin
               for (k = 0; k < TABLE_REGS; k++) begin
                  write_reg(CSR_IDX_ENTRY0 + k, 16'($urandom_range(0, 65535)));
               end
               write_reg(int'(CSR_IDX_COUNT), 16'd0);
               csr_valid    <= 1'b0;
               send_gap_max  = 14;
               take_gap_max  = 0;
            end
            4: begin
               write_reg(CSR_IDX_ENTRY0 + 0, 16'($urandom_range(0, 65535)));
               write_reg(int'(CSR_IDX_COUNT), 16'd1);
               csr_valid    <= 1'b0;
               send_gap_max  = 14;
               take_gap_max  = 14;
            end
            5: begin
               // Two entries share a module so that a command miss on one of
               // them still counts as a known module.
               write_reg(CSR_IDX_ENTRY0 + 0, 16'($urandom_range(0, 65535)));
               write_reg(CSR_IDX_ENTRY0 + 1, {8'hA7, 8'($urandom_range(0, 255))});
               write_reg(CSR_IDX_ENTRY0 + 2, {8'hA7, 8'($urandom_range(0, 255))});
               write_reg(int'(CSR_IDX_COUNT), 16'd3);
               csr_valid    <= 1'b0;
               send_gap_max  = 14;
               take_gap_max  = 14;
            end
            default: begin
               send_gap_max = 14;
               take_gap_max = 14;
            end
         endcase

         if (ph == 1) begin
            // Noise at both byte extremes, then a first sync byte that is
            // broken off.
            push_byte(8'h00);
            push_byte(8'hFF);
            push_byte(SYNC_FIRST);
            push_byte(8'h12);
            // A repeated first sync byte keeps waiting; the packet that
            // follows is empty and matches the second entry.
            push_byte(SYNC_FIRST);
            push_byte(SYNC_FIRST);
            push_byte(SYNC_SECOND);
            push_byte(8'h10);
            push_byte(8'h30);
            push_byte(8'hA5);
            push_byte(8'h00);
            push_byte(8'h00);
            push_byte(8'h12);
            push_byte(8'h34);
            // One payload byte: the byte and the summary come from the same
            // transaction. The module is known but the command is not.
            push_byte(SYNC_FIRST);
            push_byte(SYNC_SECOND);
            push_byte(8'h55);
            push_byte(8'h01);
            push_byte(8'h00);
            push_byte(8'h00);
            push_byte(8'h01);
            push_byte(8'hFF);
            push_byte(8'hFF);
            push_byte(8'h7E);
         end
         if (ph == 5) add_packet(8'hA7, 8'h00, 16'd300);

         while (queued < target) begin
            add_random_unit();
            // Halfway through this phase the sender stops until the block
            // has handed over every result.
            if (ph == 3 && queued >= target / 2 && queued < target / 2 + 12) mark_drain = 1'b1;
         end
      end

      wait_idle();
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Guard against a hang: the slowest correct run finishes far sooner.
   initial begin
      #3_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
